/* hw/rtl/binary_to_decimal_ascii_unit_assert.svh */
// Assertion macros shared by the binary-to-decimal converter modules.
// Included by the controller and the datapath; no other dependencies.
`ifndef BINARY_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTDA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BTDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/btda_pkg.sv */
// Shared constants and controller/datapath command types for the
// binary-to-decimal converter. No dependencies.
`default_nettype none

package btda_pkg;

    localparam int VALUE_WIDTH  = 64;
    localparam int MAX_DIGITS   = 20;
    localparam int STORE_SLOTS  = 20;
    localparam int DIGIT_LIMIT  = (MAX_DIGITS < 1) ? 1 :
                                  ((MAX_DIGITS > STORE_SLOTS) ? STORE_SLOTS : MAX_DIGITS);

    localparam int IN_W         = 64;
    localparam int DIGIT_CHAR_W = 6;
    localparam int DIGIT_W      = 4;

    // Long division by ten works through the quotient one chunk at a time.
    localparam int CHUNK_W      = 16;
    localparam int N_CHUNKS     = (VALUE_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int QUOT_W       = N_CHUNKS * CHUNK_W;
    localparam int CHUNK_CNT_W  = (N_CHUNKS > 1) ? $clog2(N_CHUNKS) : 1;
    localparam int DIV_W        = DIGIT_W + CHUNK_W;
    localparam int RECIP_SHIFT  = DIV_W + 3;
    localparam logic [DIV_W-1:0] RECIP = DIV_W'((1 << RECIP_SHIFT) / 10 + 1);

    localparam int COUNT_W      = $clog2(DIGIT_LIMIT + 1);
    localparam int IDX_W        = $clog2(DIGIT_LIMIT);

    localparam logic [DIGIT_CHAR_W-1:0] ASCII_ZERO = DIGIT_CHAR_W'(48);

    typedef struct packed {
        logic load;        // take a new value into the quotient register
        logic start_div;   // clear remainder and chunk counter
        logic div_step;    // process one chunk of the quotient
        logic store_zero;  // record the single digit of a zero input
        logic start_emit;  // point the read index at the top digit
        logic emit_next;   // step the read index down
    } t_dp_cmd;

    typedef struct packed {
        logic quot_zero;
        logic count_zero;
        logic count_full;
        logic chunk_last;
        logic idx_zero;
    } t_dp_status;

endpackage

`default_nettype wire

/* hw/rtl/btda_if.sv */
// Valid/ready channel interfaces for the binary-to-decimal converter.
// Depends on btda_pkg for the payload widths.
`default_nettype none

interface btda_in_if import btda_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [IN_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface btda_out_if import btda_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [DIGIT_CHAR_W-1:0] digit_char;
    logic                    last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

`default_nettype wire

/* hw/rtl/btda_datapath.sv */
// Datapath of the binary-to-decimal converter: quotient register, chunked
// divide-by-ten unit, digit store and read index. Depends on btda_pkg.
`default_nettype none
`include "binary_to_decimal_ascii_unit_assert.svh"

module btda_datapath import btda_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [IN_W-1:0]         i_value,
    input  wire t_dp_cmd                 i_cmd,
    output t_dp_status                   o_status,
    output logic [DIGIT_CHAR_W-1:0]      o_digit_char,
    output logic                         o_last_digit
);

    logic [QUOT_W-1:0]      r_quot;
    logic [DIGIT_W-1:0]     r_rem;
    logic [CHUNK_CNT_W-1:0] r_chunk;
    logic [COUNT_W-1:0]     r_count;
    logic [IDX_W-1:0]       r_idx;
    logic [DIGIT_W-1:0]     r_store [DIGIT_LIMIT];

    logic [DIV_W-1:0]       div_in;
    logic [2*DIV_W-1:0]     div_prod;
    logic [CHUNK_W-1:0]     q_chunk;
    logic [DIV_W-1:0]       q_times_ten;
    logic [DIGIT_W-1:0]     n_rem;
    logic [QUOT_W-1:0]      n_quot_shift;

    // Remainder and the top chunk form a value below ten times 2^CHUNK_W;
    // a reciprocal multiply gives its exact quotient in that range.
    assign div_in       = {r_rem, r_quot[QUOT_W-1 -: CHUNK_W]};
    assign div_prod     = {{DIV_W{1'b0}}, div_in} * {{DIV_W{1'b0}}, RECIP};
    assign q_chunk      = div_prod[RECIP_SHIFT +: CHUNK_W];
    assign q_times_ten  = ({{DIGIT_W{1'b0}}, q_chunk} << 3)
                        + ({{DIGIT_W{1'b0}}, q_chunk} << 1);
    assign n_rem        = DIGIT_W'(div_in - q_times_ten);
    assign n_quot_shift = (r_quot << CHUNK_W) | QUOT_W'(q_chunk);

    always_comb begin
        o_status.quot_zero  = (r_quot == '0);
        o_status.count_zero = (r_count == '0);
        o_status.count_full = (r_count == COUNT_W'(DIGIT_LIMIT));
        o_status.chunk_last = (r_chunk == CHUNK_CNT_W'(N_CHUNKS - 1));
        o_status.idx_zero   = (r_idx == '0);
    end

    assign o_digit_char = ASCII_ZERO + {{(DIGIT_CHAR_W - DIGIT_W){1'b0}}, r_store[r_idx]};
    assign o_last_digit = (r_idx == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quot  <= '0;
            r_rem   <= '0;
            r_chunk <= '0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_quot  <= QUOT_W'(i_value[VALUE_WIDTH-1:0]);
                r_count <= '0;
            end
            if (i_cmd.start_div) begin
                r_rem   <= '0;
                r_chunk <= '0;
            end
            if (i_cmd.div_step) begin
                r_rem  <= n_rem;
                r_quot <= n_quot_shift;
                if (o_status.chunk_last) begin
                    r_chunk <= '0;
                    r_count <= r_count + 1'b1;
                end else begin
                    r_chunk <= r_chunk + 1'b1;
                end
            end
            if (i_cmd.store_zero) begin
                r_count <= COUNT_W'(1);
            end
            if (i_cmd.start_emit) begin
                r_idx <= IDX_W'(r_count - 1'b1);
            end
            if (i_cmd.emit_next) begin
                r_idx <= r_idx - 1'b1;
            end
        end
    end

    // Digit store has no reset; every slot is written before it is read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_step && o_status.chunk_last) begin
            r_store[r_count[IDX_W-1:0]] <= n_rem;
        end else if (i_cmd.store_zero) begin
            r_store[0] <= '0;
        end
    end

    `BTDA_ASSERT_SAME(a_count_bounded, i_clk, i_rst_n, 1'b1,
        r_count <= COUNT_W'(DIGIT_LIMIT), "digit count exceeds store size")
    `BTDA_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, i_cmd.div_step && o_status.chunk_last,
        r_count == COUNT_W'($past(r_count) + 1'b1), "digit count did not advance")
    `BTDA_ASSERT_NEXT(a_emit_start, i_clk, i_rst_n, i_cmd.start_emit,
        r_idx == IDX_W'(r_count - 1'b1), "read index not at top digit")

endmodule

`default_nettype wire

/* hw/rtl/btda_ctrl.sv */
// Controller of the binary-to-decimal converter: sequences load, divide
// steps and digit emission. Depends on btda_pkg and the assertion macros.
`default_nettype none
`include "binary_to_decimal_ascii_unit_assert.svh"

module btda_ctrl import btda_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_dp_cmd         o_cmd,
    input  wire t_dp_status i_status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready, n_in_ready;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_in_ready  = r_in_ready;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_in_ready = 1'b0;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_status.quot_zero || i_status.count_full) begin
                    if (i_status.count_zero) begin
                        // A zero input still produces one '0' character.
                        o_cmd.store_zero = 1'b1;
                    end else begin
                        o_cmd.start_emit = 1'b1;
                        n_out_valid      = 1'b1;
                        n_state          = ST_EMIT;
                    end
                end else begin
                    o_cmd.start_div = 1'b1;
                    n_state         = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.chunk_last) begin
                    n_state = ST_CHECK;
                end
            end
            ST_EMIT: begin
                if (i_out_ready) begin
                    if (i_status.idx_zero) begin
                        n_out_valid = 1'b0;
                        n_in_ready  = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                    end
                end
            end
            default: begin
                n_state     = ST_IDLE;
                n_in_ready  = 1'b1;
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= n_in_ready;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

    `BTDA_ASSERT_SAME(a_ready_valid_excl, i_clk, i_rst_n, o_in_ready,
        !o_out_valid, "input ready while digits still pending")
    `BTDA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && o_in_ready,
        !o_in_ready && !o_out_valid, "block not busy after a request")
    `BTDA_ASSERT_NEXT(a_digits_contiguous, i_clk, i_rst_n,
        o_out_valid && i_out_ready && !i_status.idx_zero,
        o_out_valid, "digit run ended before its last digit")

endmodule

`default_nettype wire

/* hw/rtl/binary_to_decimal_ascii_unit.sv */
// Converts one unsigned binary number per request into decimal ASCII digits,
// most significant first, without leading zeros; zero gives a single '0' and
// the final digit carries last_digit. One request is handled at a time. Each
// digit costs one pass through the check state plus N_CHUNKS (4 for a 64-bit
// value) steps of the 16-bit-per-cycle divide-by-ten unit; the digits are then
// sent one per cycle while the sink is ready.
// Depends on btda_pkg, btda_if, btda_ctrl and btda_datapath.
`default_nettype none

module binary_to_decimal_ascii_unit import btda_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    btda_in_if.sink    i_req,
    btda_out_if.source o_dig
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       in_ready;
    logic       out_valid;

    btda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_dig.ready),
        .o_cmd       (dp_cmd),
        .i_status    (dp_status)
    );

    btda_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value      (i_req.value),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .o_digit_char (o_dig.digit_char),
        .o_last_digit (o_dig.last_digit)
    );

    assign i_req.ready = in_ready;
    assign o_dig.valid = out_valid;

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for binary_to_decimal_ascii_unit: numbers go in as requests and
// each digit that comes out is checked against digits worked out here by repeated division.
// Depends on btda_pkg, btda_if and the RTL of the converter.
`timescale 1ns / 100ps

module tb;
    import btda_pkg::*;

    localparam int RANDOM_NUMBERS = 210;
    localparam int DRAIN_CYCLES   = 160;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PRESSURE_AT    = 300;
    localparam int PRESSURE_HOLD  = 400;

    localparam logic [IN_W-1:0] VALUE_MASK = {IN_W{1'b1}} >> (IN_W - VALUE_WIDTH);

    typedef struct packed {
        logic [DIGIT_CHAR_W-1:0] digit_char;
        logic                    last_digit;
    } t_digit;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    btda_in_if  req_if ();
    btda_out_if dig_if ();

    binary_to_decimal_ascii_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_dig   (dig_if)
    );

    logic [IN_W-1:0] numbers_to_send[$];
    t_digit          expected_digits[$];
    int              error_count = 0;
    int              numbers_sent = 0;
    int              digits_seen = 0;
    int              send_gap = 0;
    int              sink_stall = 0;
    int              hold_left = 0;
    int              quiet_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Every third block of a hundred counts runs with no idling at all.
    function automatic int draw_wait(int count);
        if ((count / 100) % 3 == 1)
            return 0;
        return $urandom_range(0, 7);
    endfunction

    // Divides by ten until the quotient is zero, then queues the remainders
    // most significant first; only the last one carries the final-digit flag.
    function automatic void queue_decimal_digits(logic [IN_W-1:0] raw);
        logic [IN_W-1:0]    quotient;
        logic [DIGIT_W-1:0] remainders[$];
        t_digit             d;
        quotient = raw & VALUE_MASK;
        if (quotient == '0) begin
            d.digit_char = ASCII_ZERO;
            d.last_digit = 1'b1;
            expected_digits.push_back(d);
            return;
        end
        while (quotient != '0 && remainders.size() < DIGIT_LIMIT) begin
            remainders.push_back(DIGIT_W'(quotient % 10));
            quotient = quotient / 10;
        end
        for (int k = remainders.size() - 1; k >= 0; k--) begin
            d.digit_char = ASCII_ZERO + DIGIT_CHAR_W'(remainders[k]);
            d.last_digit = (k == 0);
            expected_digits.push_back(d);
        end
    endfunction

    // Request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.value <= '0;
            send_gap = draw_wait(0);
        end else if (!req_if.valid || req_if.ready) begin
            if (req_if.valid) begin
                queue_decimal_digits(req_if.value);
                numbers_sent++;
                send_gap = draw_wait(numbers_sent);
            end
            if (send_gap > 0) begin
                send_gap--;
                req_if.valid <= 1'b0;
            end else if (numbers_to_send.size() > 0) begin
                req_if.valid <= 1'b1;
                req_if.value <= numbers_to_send.pop_front();
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Digit monitor and sink; one long hold-off lets the converter back up.
    always @(posedge i_clk) begin
        t_digit want;
        if (!i_rst_n) begin
            dig_if.ready <= 1'b0;
            sink_stall = draw_wait(0);
            hold_left = 0;
        end else begin
            if (dig_if.valid && dig_if.ready) begin
                digits_seen++;
                if (expected_digits.size() == 0) begin
                    $error("unexpected digit %0d with nothing pending", dig_if.digit_char);
                    error_count++;
                end else begin
                    want = expected_digits.pop_front();
                    if (dig_if.digit_char !== want.digit_char) begin
                        $error("digit_char: expected %0d, got %0d",
                               want.digit_char, dig_if.digit_char);
                        error_count++;
                    end
                    if (dig_if.last_digit !== want.last_digit) begin
                        $error("last_digit: expected %0d, got %0d",
                               want.last_digit, dig_if.last_digit);
                        error_count++;
                    end
                end
                sink_stall = draw_wait(digits_seen);
                if (digits_seen == PRESSURE_AT)
                    hold_left = PRESSURE_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                dig_if.ready <= 1'b0;
            end else if (sink_stall > 0) begin
                sink_stall--;
                dig_if.ready <= 1'b0;
            end else begin
                dig_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (dig_if.valid && dig_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [IN_W-1:0] power_of_ten;
        logic [IN_W-1:0] num;
        int              exponent;
        req_if.valid = 1'b0;
        req_if.value = '0;
        dig_if.ready = 1'b0;

        // Zero, single digits, carries across powers of ten, the largest
        // value and alternating bit patterns.
        numbers_to_send = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd11, 64'd99, 64'd100,
                            64'd12345, 64'd4294967295, 64'd4294967296,
                            64'd999999999999999999, 64'd1000000000000000000,
                            64'd9999999999999999999, 64'd10000000000000000000,
                            64'd10000000000000000001, 64'd18446744073709551615,
                            64'd9223372036854775808, 64'hAAAAAAAAAAAAAAAA,
                            64'h5555555555555555, 64'd12345678901234567890};

        for (int i = 0; i < RANDOM_NUMBERS; i++) begin
            case ($urandom_range(0, 3))
                0: num = {$urandom, $urandom};
                1: num = {$urandom, $urandom} >> $urandom_range(0, 63);
                2: begin
                    exponent = $urandom_range(0, 19);
                    power_of_ten = 64'd1;
                    for (int e = 0; e < exponent; e++)
                        power_of_ten = power_of_ten * 10;
                    num = power_of_ten + $urandom_range(0, 2) - 1;
                end
                default: num = $urandom_range(0, 999);
            endcase
            numbers_to_send.push_back(num);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (numbers_to_send.size() > 0 || req_if.valid || expected_digits.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_digits.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
